// File: hdl/shortest_remaining_time_scheduler_core_defines.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_CORE_DEFINES_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/srt_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Types and constants shared by the scheduler cells and the top level.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int unsigned TimeW  = 21;
  localparam int unsigned ValW   = 16;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned StatW  = 2;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic [StatW-1:0] STAT_RAN  = 2'd0;
  localparam logic [StatW-1:0] STAT_IDLE = 2'd1;
  localparam logic [StatW-1:0] STAT_DONE = 2'd2;

  // Scan token that travels down the chain of cells.
  typedef struct packed {
    logic            valid;
    logic            found;  // an eligible slot has been seen
    logic            pend;   // a slot in use has not yet arrived
    logic [ValW-1:0] rem;    // remaining burst of the best slot
    logic [ValW-1:0] arr;    // arrival of the best slot
    logic [ValW-1:0] init;   // initial burst of the best slot
  } tok_t;

  // Load write broadcast to every cell.
  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] slot;
    logic [ValW-1:0]  arr;
    logic [ValW-1:0]  bur;
  } ld_t;

endpackage

// File: hdl/shortest_remaining_time_scheduler_core.sv
// Transfers: a load transfer gives no result; a tick transfer gives its result once the
// scan token, walking the chain one cell per cycle, has passed every cell register, then
// the captured-token and result registers; a stalled output holds it back. A new tick is
// taken only after the last is committed; loads go one per cycle while no tick is busy.
// Reset: rst_ni is asynchronous and active low; it clears time to zero, sets the process
// count to one and empties the pipeline; slot contents are undefined until loaded.
`include "shortest_remaining_time_scheduler_core_defines.svh"
// ----------------------------------------------------------------------------
// Shortest-remaining-time scheduler core
// Preemptive SRTF scheduler built as a chain of slot cells that a scan token
// walks through to find the eligible slot with the least remaining burst.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_core #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: process count.
  input  logic                        cfg_we_i,
  input  logic [srt_pkg::CountW-1:0]  cfg_wdata_i,
  // Request channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [srt_pkg::SlotW-1:0]   slot_i,
  input  logic [srt_pkg::ValW-1:0]    arrival_time_i,
  input  logic [srt_pkg::ValW-1:0]    burst_time_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srt_pkg::StatW-1:0]   status_o,
  output logic [srt_pkg::SlotW-1:0]   run_slot_o,
  output logic                        finished_o,
  output logic [srt_pkg::TimeW-1:0]   turnaround_o,
  output logic [srt_pkg::TimeW-1:0]   waiting_o
);
  import srt_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_PROCESSES);

  // Control states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] count_q;
  logic [TimeW-1:0]  time_q, time_d, time_next;

  logic in_xfer, tick_start, commit;

  // Scan chain: tok[k] enters cell k, tok[MAX_PROCESSES] leaves the last cell.
  tok_t                tok [MAX_PROCESSES+1];
  logic [IdxW-1:0]     idx [MAX_PROCESSES+1];
  logic [MAX_PROCESSES-1:0] tok_vld;
  ld_t                 ld;
  logic                dec_en;

  // Token captured from the end of the chain, waiting to be committed.
  tok_t            res_q;
  logic [IdxW-1:0] res_idx_q;

  // Result register.
  logic              out_valid_q;
  logic [StatW-1:0]  status_q, status_d;
  logic [SlotW-1:0]  run_slot_q, run_slot_d;
  logic              finished_q, finished_d;
  logic [TimeW-1:0]  turn_q, turn_d, wait_q, wait_d;
  logic [TimeW-1:0]  init_ext;

  // The block takes one transfer at a time and only while no tick is being
  // worked on. Loads never produce a result, so they may follow each other
  // in consecutive cycles.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign tick_start = in_xfer && req_type_i;

  always_comb begin
    ld.we   = in_xfer && !req_type_i;
    ld.slot = slot_i;
    ld.arr  = arrival_time_i;
    ld.bur  = burst_time_i;
  end

  // The token is injected combinationally into the first cell on the edge
  // that accepts a tick, so the first cell registers it right away.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = tick_start;
    idx[0]       = '0;
  end

  for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
    srt_cell #(
      .IdxW (IdxW),
      .Idx  (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cnt_i     (count_q),
      .time_i    (time_q),
      .ld_i      (ld),
      .dec_en_i  (dec_en),
      .dec_idx_i (res_idx_q),
      .tok_i     (tok[g]),
      .idx_i     (idx[g]),
      .tok_o     (tok[g+1]),
      .idx_o     (idx[g+1])
    );
    assign tok_vld[g] = tok[g+1].valid;
  end

  // The result slot frees up when it is empty or being transferred now.
  assign commit = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);
  assign dec_en = commit && res_q.found;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[MAX_PROCESSES].valid) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Time saturates at its maximum. It advances when a slot runs or when the
  // tick idles for a later arrival, and stays put once everything is done.
  assign time_next = (time_q == TimeMax) ? time_q : time_q + TimeW'(1);
  assign init_ext  = {{(TimeW-ValW){1'b0}}, res_q.init};

  always_comb begin
    time_d     = time_q;
    status_d   = STAT_DONE;
    run_slot_d = '0;
    finished_d = 1'b0;
    turn_d     = '0;
    wait_d     = '0;
    if (res_q.found) begin
      status_d   = STAT_RAN;
      run_slot_d = SlotW'(res_idx_q);
      time_d     = time_next;
      // The run leaves the burst at zero exactly when one tick remained.
      if (res_q.rem == ValW'(1)) begin
        finished_d = 1'b1;
        turn_d     = time_next - {{(TimeW-ValW){1'b0}}, res_q.arr};
        // Turnaround can fall below the burst only after time saturated.
        wait_d     = (turn_d >= init_ext) ? turn_d - init_ext : '0;
      end
    end else if (res_q.pend) begin
      status_d = STAT_IDLE;
      time_d   = time_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CountW'(1);
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (commit) begin
        time_q      <= time_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && tok[MAX_PROCESSES].valid) begin
      res_q     <= tok[MAX_PROCESSES];
      res_idx_q <= idx[MAX_PROCESSES];
    end
    if (commit) begin
      status_q   <= status_d;
      run_slot_q <= run_slot_d;
      finished_q <= finished_d;
      turn_q     <= turn_d;
      wait_q     <= wait_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign run_slot_o   = run_slot_q;
  assign finished_o   = finished_q;
  assign turnaround_o = turn_q;
  assign waiting_o    = wait_q;

  // Only one scan token may be in the chain at any time.
  `SRT_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vld), "more than one scan token in flight")
  // A committed run never picks a slot whose burst is already exhausted.
  `SRT_ASSERT_NOW(a_dec_nonzero, dec_en, res_q.rem != '0, "decrement of an empty burst")
  // Time never moves backward.
  `SRT_ASSERT_NEXT(a_time_mono, 1'b1, time_q >= $past(time_q), "current time decreased")
  // A completion is only reported for a slot that actually ran.
  `SRT_ASSERT_NOW(a_fin_ran, out_valid_q && finished_q, status_q == STAT_RAN,
                  "completion reported without a run")

endmodule

// File: hdl/srt_cell.sv
// ----------------------------------------------------------------------------
// Scheduler cell
// Holds one process slot and updates the passing scan token with it.
// ----------------------------------------------------------------------------
module srt_cell #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [srt_pkg::CountW-1:0]  cnt_i,
  input  logic [srt_pkg::TimeW-1:0]   time_i,
  input  srt_pkg::ld_t                ld_i,
  input  logic                        dec_en_i,
  input  logic [IdxW-1:0]             dec_idx_i,
  input  srt_pkg::tok_t               tok_i,
  input  logic [IdxW-1:0]             idx_i,
  output srt_pkg::tok_t               tok_o,
  output logic [IdxW-1:0]             idx_o
);
  import srt_pkg::*;

  logic [ValW-1:0] arr_q, rem_q, init_q;
  logic            in_use, arrived, better;
  tok_t            tok_d, tok_q;
  logic [IdxW-1:0] idx_d, idx_q;

  // Slot storage: a load overwrites everything, a run decrements the burst.
  always_ff @(posedge clk_i) begin
    if (ld_i.we && (int'(ld_i.slot) == int'(Idx))) begin
      arr_q  <= ld_i.arr;
      rem_q  <= ld_i.bur;
      init_q <= ld_i.bur;
    end else if (dec_en_i && (int'(dec_idx_i) == int'(Idx))) begin
      rem_q <= rem_q - ValW'(1);
    end
  end

  always_comb begin
    in_use  = int'(cnt_i) > int'(Idx);
    arrived = {{(TimeW-ValW){1'b0}}, arr_q} <= time_i;
    // Strict compare keeps the earlier slot on a tie.
    better  = tok_i.valid && in_use && arrived && (rem_q != '0) &&
              (!tok_i.found || (rem_q < tok_i.rem));
    tok_d       = tok_i;
    tok_d.found = tok_i.found | better;
    tok_d.pend  = tok_i.pend | (in_use && !arrived);
    idx_d       = idx_i;
    if (better) begin
      tok_d.rem  = rem_q;
      tok_d.arr  = arr_q;
      tok_d.init = init_q;
      idx_d      = IdxW'(Idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      idx_q <= '0;
    end else begin
      tok_q <= tok_d;
      idx_q <= idx_d;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule
